@@ design/icsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsu_pkg
// Shared widths, register indexes, sequencer states and control types of the
// interval counter sampler.
// ----------------------------------------------------------------------------
package icsu_pkg;

    localparam int unsigned TIME_W     = 64;
    localparam int unsigned VAL_W      = 48;
    localparam int unsigned NUM_CNT    = 4;
    localparam int unsigned ECNT_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    // Operand half widths of the shared 32x32 multiplier.
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned PROD_W     = 2 * HALF_W;

    // Signed accumulator for L*(now-Pt) + P*(Lt-now): each term is below 2^112.
    localparam int unsigned ACC_W      = 115;
    // Magnitude bits handed to the divider when the sum is not negative.
    localparam int unsigned NUM_W      = 113;

    // Eight partial products per counter, then the adder is drained.
    localparam int unsigned MUL_ISSUE  = 8;
    localparam int unsigned MUL_CNT_W  = 4;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT       = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       clr;
        logic       issue;
        logic [1:0] shift;   // partial product weight in units of 2^32
        logic       neg;     // subtract the partial product
    } t_mac_ctl;

endpackage
`default_nettype wire

@@ design/icsu_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsu_mac
// Shared 32x32 multiplier with a registered product, feeding a signed
// accumulator that adds or subtracts the shifted partial product.
// ----------------------------------------------------------------------------
module icsu_mac
    import icsu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mac_ctl         i_ctl,
    input  wire logic [HALF_W-1:0] i_a,
    input  wire logic [HALF_W-1:0] i_b,
    output logic      [ACC_W-1:0] o_acc
);

    logic [PROD_W-1:0] r_prod;
    logic              r_pp_vld;
    logic [1:0]        r_pp_shift;
    logic              r_pp_neg;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  w_term;

    always_comb begin
        case (r_pp_shift)
            2'd0:    w_term = ACC_W'(r_prod);
            2'd1:    w_term = ACC_W'(r_prod) << HALF_W;
            2'd2:    w_term = ACC_W'(r_prod) << (2 * HALF_W);
            default: w_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_pp_vld <= i_ctl.issue;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_pp_vld) begin
                r_acc <= r_pp_neg ? (r_acc - w_term) : (r_acc + w_term);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod     <= i_a * i_b;
            r_pp_shift <= i_ctl.shift;
            r_pp_neg   <= i_ctl.neg;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

@@ design/icsu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsu_div
// Restoring divider, one quotient bit per cycle, with the quotient clamped
// to the counter range.
// ----------------------------------------------------------------------------
module icsu_div
    import icsu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [TIME_W-1:0] i_den,
    output logic                   o_done,
    output logic      [VAL_W-1:0]  o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [TIME_W-1:0] r_den;
    logic [TIME_W-1:0] r_rem;
    logic [VAL_W-1:0]  r_q;
    logic              r_ovf;
    logic [TIME_W:0]   w_trial;
    logic              w_ge;

    // The remainder stays below the divisor, so the shifted value fits in 65 bits.
    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? TIME_W'(w_trial - {1'b0, r_den}) : TIME_W'(w_trial);
            r_q   <= {r_q[VAL_W-2:0], w_ge};
            r_ovf <= r_ovf | r_q[VAL_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? VAL_MAX : r_q;

endmodule
`default_nettype wire

@@ design/interval_counter_sampler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_counter_sampler_unit
// Rate-limited counter sampler that extrapolates between stored samples.
// ----------------------------------------------------------------------------
// A request at or past the next sampling time takes the live counter values
// (or flags a failed read). Such a request, one that finds the stored sample
// times not increasing and one with no active counters all go from the idle
// state to the emit state; their result becomes valid as the input is ready
// again, unless the emit state waits on an untaken result. Other requests are
// answered with the straight-line value through the two stored samples,
// computed per active counter by one shared 32x32 multiplier (eight partial
// products, a drain of the adder and a sign check) and one restoring divider
// (113 quotient bits and a handoff, skipped when the line is negative). The
// active counters are worked on one after another after a prepare state, and
// the result leaves through the emit state. The input is not ready while a
// request is being worked on; a finished result waits in the output register
// and does not hold up the acceptance of the next request, but that request's
// emit state waits until it is taken. The configuration port is always ready.
// ----------------------------------------------------------------------------
module interval_counter_sampler_unit
    import icsu_pkg::*;
#(
    parameter int unsigned COUNTER_SLOTS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [TIME_W-1:0]     i_now_time,
    input  wire logic [VAL_W-1:0]      i_live_count_0,
    input  wire logic [VAL_W-1:0]      i_live_count_1,
    input  wire logic [VAL_W-1:0]      i_live_count_2,
    input  wire logic [VAL_W-1:0]      i_live_count_3,
    input  wire logic                  i_live_valid,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [VAL_W-1:0]      o_out_value_0,
    output logic      [VAL_W-1:0]      o_out_value_1,
    output logic      [VAL_W-1:0]      o_out_value_2,
    output logic      [VAL_W-1:0]      o_out_value_3,
    output logic                       o_was_sampled,
    output logic                       o_read_status
);

    localparam int unsigned SLOTS  = (COUNTER_SLOTS < NUM_CNT) ? COUNTER_SLOTS : NUM_CNT;
    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state r_state;
    t_state n_state;

    logic [TIME_W-1:0]    r_sampling_interval;
    logic [ECNT_W-1:0]    r_event_count;
    logic [TIME_W-1:0]    r_next_time;
    logic [TIME_W-1:0]    r_prev_time;
    logic [TIME_W-1:0]    r_last_time;
    logic [VAL_W-1:0]     r_prev_val [SLOTS];
    logic [VAL_W-1:0]     r_last_val [SLOTS];

    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_mag0;
    logic [TIME_W-1:0]    r_mag1;
    logic                 r_neg0;
    logic                 r_neg1;
    logic [TIME_W-1:0]    r_den;
    logic [SLOT_W-1:0]    r_slot;
    logic [MUL_CNT_W-1:0] r_cnt;

    logic [VAL_W-1:0]     r_res_val [SLOTS];
    logic                 r_res_sampled;
    logic                 r_res_status;

    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_out_val [SLOTS];
    logic                 r_out_sampled;
    logic                 r_out_status;

    logic [VAL_W-1:0]     w_live [NUM_CNT];
    logic [VAL_W-1:0]     w_out  [NUM_CNT];
    logic [ECNT_W-1:0]    w_active;
    logic                 w_in_acc;
    logic                 w_due;
    logic                 w_rising;
    logic                 w_extrap;
    logic                 w_last_slot;
    logic                 w_mul_done;
    logic                 w_acc_neg;
    logic                 w_out_free;

    t_mac_ctl             w_mac_ctl;
    logic [HALF_W-1:0]    w_mac_a;
    logic [HALF_W-1:0]    w_mac_b;
    logic [ACC_W-1:0]     w_acc;
    logic [VAL_W-1:0]     w_term_val;
    logic [TIME_W-1:0]    w_term_mag;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [VAL_W-1:0]     w_div_quot;

    assign w_live[0] = i_live_count_0;
    assign w_live[1] = i_live_count_1;
    assign w_live[2] = i_live_count_2;
    assign w_live[3] = i_live_count_3;

    assign w_active    = (r_event_count > ECNT_W'(SLOTS)) ? ECNT_W'(SLOTS) : r_event_count;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_due       = (i_now_time >= r_next_time);
    assign w_rising    = (r_last_time > r_prev_time);
    assign w_extrap    = (w_active != '0) && !w_due && w_rising;
    assign w_last_slot = ((ECNT_W'(r_slot) + ECNT_W'(1)) == w_active);
    assign w_mul_done  = (r_cnt == MUL_CNT_W'(MUL_ISSUE + 1));
    assign w_acc_neg   = w_acc[ACC_W-1];
    assign w_out_free  = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_extrap ? S_PREP : S_EMIT;
                end
            end
            S_PREP: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    if (!w_acc_neg) begin
                        n_state = S_DIV;
                    end else if (w_last_slot) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = w_last_slot ? S_EMIT : S_MUL;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- controls
    always_comb begin
        o_in_ready      = 1'b0;
        w_mac_ctl       = '0;
        w_div_start     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_MUL: begin
                w_mac_ctl.clr   = (r_cnt == '0);
                w_mac_ctl.issue = (r_cnt < MUL_CNT_W'(MUL_ISSUE));
                w_mac_ctl.shift = 2'(r_cnt[0]) + 2'(r_cnt[1]);
                w_mac_ctl.neg   = r_cnt[2] ? r_neg1 : r_neg0;
                w_div_start     = w_mul_done && !w_acc_neg;
            end
            default: begin
            end
        endcase
    end

    // Partial products: the first four form L*(now-Pt), the last four P*(Lt-now).
    assign w_term_val = r_cnt[2] ? r_prev_val[r_slot] : r_last_val[r_slot];
    assign w_term_mag = r_cnt[2] ? r_mag1 : r_mag0;
    assign w_mac_a    = r_cnt[0] ? HALF_W'(w_term_val[VAL_W-1:HALF_W])
                                 : w_term_val[HALF_W-1:0];
    assign w_mac_b    = r_cnt[1] ? w_term_mag[TIME_W-1:HALF_W] : w_term_mag[HALF_W-1:0];

    icsu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc)
    );

    icsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc[NUM_W-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ---------------------------------------------------------------- state regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_IDLE;
            r_sampling_interval <= '0;
            r_event_count       <= '0;
            r_next_time         <= '0;
            r_prev_time         <= '0;
            r_last_time         <= '0;
            r_out_valid         <= 1'b0;
            r_slot              <= '0;
            r_cnt               <= '0;
            for (int c = 0; c < SLOTS; c++) begin
                r_prev_val[c] <= '0;
                r_last_val[c] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SAMPLING_INTERVAL: r_sampling_interval <= i_cfg_data;
                    CFG_EVENT_COUNT:       r_event_count <= i_cfg_data[ECNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // A new result may replace one that is taken in the same cycle.
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_active != '0) && w_due) begin
                        r_next_time <= i_now_time + r_sampling_interval;
                        if (i_live_valid) begin
                            r_prev_time <= r_last_time;
                            r_last_time <= i_now_time;
                            for (int c = 0; c < SLOTS; c++) begin
                                if (ECNT_W'(c) < w_active) begin
                                    r_prev_val[c] <= r_last_val[c];
                                    r_last_val[c] <= w_live[c];
                                end
                            end
                        end
                    end
                    r_slot <= '0;
                end
                S_PREP: begin
                    r_cnt <= '0;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        if (w_acc_neg) begin
                            r_slot <= r_slot + SLOT_W'(1);
                            r_cnt  <= '0;
                        end
                    end else begin
                        r_cnt <= r_cnt + MUL_CNT_W'(1);
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_slot <= r_slot + SLOT_W'(1);
                        r_cnt  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_now         <= i_now_time;
                    r_res_sampled <= 1'b0;
                    r_res_status  <= 1'b0;
                    for (int c = 0; c < SLOTS; c++) begin
                        r_res_val[c] <= '0;
                    end
                    if (w_active != '0) begin
                        if (w_due) begin
                            if (!i_live_valid) begin
                                r_res_status <= 1'b1;
                            end else begin
                                r_res_sampled <= 1'b1;
                                for (int c = 0; c < SLOTS; c++) begin
                                    if (ECNT_W'(c) < w_active) begin
                                        r_res_val[c] <= w_live[c];
                                    end
                                end
                            end
                        end else if (!w_rising) begin
                            // Stored times not increasing: hold the last sample.
                            for (int c = 0; c < SLOTS; c++) begin
                                if (ECNT_W'(c) < w_active) begin
                                    r_res_val[c] <= r_last_val[c];
                                end
                            end
                        end
                    end
                end
            end
            S_PREP: begin
                r_neg0 <= (r_now < r_prev_time);
                r_mag0 <= (r_now < r_prev_time) ? (r_prev_time - r_now)
                                                : (r_now - r_prev_time);
                r_neg1 <= (r_last_time < r_now);
                r_mag1 <= (r_last_time < r_now) ? (r_now - r_last_time)
                                                : (r_last_time - r_now);
                r_den  <= r_last_time - r_prev_time;
            end
            S_MUL: begin
                if (w_mul_done && w_acc_neg) begin
                    r_res_val[r_slot] <= '0;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_res_val[r_slot] <= w_div_quot;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out_sampled <= r_res_sampled;
                    r_out_status  <= r_res_status;
                    for (int c = 0; c < SLOTS; c++) begin
                        r_out_val[c] <= r_res_val[c];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < NUM_CNT; g++) begin : g_out
        if (g < SLOTS) begin : g_used
            assign w_out[g] = r_out_val[g];
        end else begin : g_unused
            assign w_out[g] = '0;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_value_0 = w_out[0];
    assign o_out_value_1 = w_out[1];
    assign o_out_value_2 = w_out[2];
    assign o_out_value_3 = w_out[3];
    assign o_was_sampled = r_out_sampled;
    assign o_read_status = r_out_status;

endmodule
`default_nettype wire

@@ design/icsu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsu_checker
// Port-level checks of the interval counter sampler, bound to the top level.
// ----------------------------------------------------------------------------
module icsu_checker
    import icsu_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [VAL_W-1:0] o_out_value_0,
    input wire logic [VAL_W-1:0] o_out_value_1,
    input wire logic [VAL_W-1:0] o_out_value_2,
    input wire logic [VAL_W-1:0] o_out_value_3,
    input wire logic             o_was_sampled,
    input wire logic             o_read_status
);

    // A result beat is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_value_0) && $stable(o_out_value_1)
            && $stable(o_out_value_2) && $stable(o_out_value_3)
            && $stable(o_was_sampled) && $stable(o_read_status))
        else $error("stalled result beat changed");

    // One request at a time: the input closes right after a beat is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready while a request is in progress");

    // A result never shows up in the cycle right after its request was taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after the request");

    // A failed live read reports no values and no sample.
    a_fail_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_status |-> !o_was_sampled && (o_out_value_0 == '0)
            && (o_out_value_1 == '0) && (o_out_value_2 == '0) && (o_out_value_3 == '0))
        else $error("failed read carries values");

endmodule

bind interval_counter_sampler_unit icsu_checker u_icsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_value_0 (o_out_value_0),
    .o_out_value_1 (o_out_value_1),
    .o_out_value_2 (o_out_value_2),
    .o_out_value_3 (o_out_value_3),
    .o_was_sampled (o_was_sampled),
    .o_read_status (o_read_status)
);
`default_nettype wire
